// ===== hw/rtl/upd_pkg.sv =====
// Package for the URL path decode/validate block: types, codes and helpers.
// Used by upd_step and url_path_decode_validate_top. No dependencies.
`default_nettype none

package upd_pkg;

    // Sizes
    localparam int MAX_PATH = 4096;         // relative bytes emitted per path at most
    localparam int CNT_W    = 13;           // counter and register width
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam int NUM_RES  = 4;            // results one item can cause
    localparam int NUM_SLOT = 5;            // decode slots per item

    // Configuration register indexes
    localparam logic CFG_MAX_RAW   = 1'b0;
    localparam logic CFG_PATH_ROOM = 1'b1;
    localparam logic [CNT_W-1:0] RST_MAX_RAW   = 13'd1024;
    localparam logic [CNT_W-1:0] RST_PATH_ROOM = 13'd1024;

    // Verdict error codes
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_NO_ROOM = 3'd1;
    localparam logic [2:0] ERR_RAW_LEN = 3'd2;
    localparam logic [2:0] ERR_DOTDOT  = 3'd3;
    localparam logic [2:0] ERR_DSLASH  = 3'd4;
    localparam logic [2:0] ERR_BADCH   = 3'd5;
    localparam logic [2:0] ERR_HIDDEN  = 3'd6;
    localparam logic [2:0] ERR_TOOLONG = 3'd7;

    // Result kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Characters
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_USCR  = 8'h5F;

    // Fault flag bits
    localparam int FL_DOTDOT = 0;
    localparam int FL_DSLASH = 1;
    localparam int FL_BADCH  = 2;
    localparam int FL_HIDDEN = 3;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,   // no escape pending
        ESC_PCT   = 2'd1,   // '%' seen
        ESC_DIGIT = 2'd2,   // '%' and one hex digit seen
        ESC_ENDED = 2'd3    // raw zero seen, rest ignored
    } t_esc;

    typedef enum logic [1:0] {
        POS_START = 2'd0,
        POS_SLASH = 2'd1,   // after the leading slash
        POS_INSIDE = 2'd2
    } t_pos;

    // Decoded-byte tracking state
    typedef struct packed {
        logic [7:0]       prev;
        t_pos             pos;
        logic             cut;
        logic [3:0]       flags;
        logic [CNT_W-1:0] path_count;
    } t_dec_state;

    // Whole per-path context
    typedef struct packed {
        t_esc             esc;
        logic [7:0]       held;
        logic [CNT_W-1:0] raw_count;
        t_dec_state       dec;
    } t_ctx;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       accepted;
        logic [2:0] err;
        logic       last;
    } t_result;

    typedef struct packed {
        t_dec_state st;
        logic       emit;
        logic [7:0] data;
    } t_dec_res;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic char_ok(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A) || c == CH_SLASH || c == CH_DOT ||
               c == CH_DASH || c == CH_USCR || c == CH_SPACE;
    endfunction

    // One decoded byte: checks, position tracking, emission
    function automatic t_dec_res dec_byte(t_dec_state s, logic [7:0] c, logic en);
        t_dec_res r;
        r.st   = s;
        r.emit = 1'b0;
        r.data = (c == CH_SLASH) ? CH_BSL : c;
        if (en && !s.cut) begin
            if (c == 8'd0) begin
                r.st.cut = 1'b1;
            end else begin
                if (s.prev == CH_DOT && c == CH_DOT) r.st.flags[FL_DOTDOT] = 1'b1;
                if (s.prev == CH_SLASH && c == CH_SLASH) r.st.flags[FL_DSLASH] = 1'b1;
                r.st.prev = c;
                if (s.pos == POS_START && c == CH_SLASH) begin
                    r.st.pos = POS_SLASH;
                end else begin
                    if (s.pos != POS_INSIDE && c == CH_DOT) r.st.flags[FL_HIDDEN] = 1'b1;
                    r.st.pos = POS_INSIDE;
                    if (!char_ok(c)) r.st.flags[FL_BADCH] = 1'b1;
                    r.emit = (32'(s.path_count) < 32'(MAX_PATH));
                    if (s.path_count != CNT_MAX) r.st.path_count = s.path_count + 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/upd_step.sv =====
// Combinational step of the URL path decoder: one raw item against the context.
// Depends on upd_pkg. Gives the next context and up to four ordered results.
`default_nettype none

module upd_step (
    input  wire upd_pkg::t_ctx               i_ctx,
    input  wire logic [7:0]                  i_byte,
    input  wire logic                        i_has_byte,
    input  wire logic                        i_last,
    input  wire logic [upd_pkg::CNT_W-1:0]   i_max_raw,
    input  wire logic [upd_pkg::CNT_W-1:0]   i_path_room,
    output upd_pkg::t_ctx                    o_ctx,
    output upd_pkg::t_result [upd_pkg::NUM_RES-1:0] o_res,
    output logic [2:0]                       o_num
);
    import upd_pkg::*;

    logic [7:0] slot_c  [NUM_SLOT];
    logic       slot_en [NUM_SLOT];
    logic [4:0] hv_in;
    logic [4:0] hv_held;
    logic [7:0] fresh_c;
    logic       cut_after;
    t_esc       esc;
    logic [7:0] held;
    logic [CNT_W-1:0] raw;
    t_dec_state st;
    t_dec_res   dr;
    logic [2:0] n;
    logic [2:0] err;
    t_result    res [NUM_RES];

    assign hv_in   = hex_val(i_byte);
    assign hv_held = hex_val(i_ctx.held);
    assign fresh_c = (i_byte == CH_PLUS) ? CH_SPACE : i_byte;

    always_comb begin
        esc       = i_ctx.esc;
        held      = i_ctx.held;
        raw       = i_ctx.raw_count;
        cut_after = 1'b0;
        for (int i = 0; i < NUM_SLOT; i++) begin
            slot_c[i]  = 8'd0;
            slot_en[i] = 1'b0;
        end

        // Raw byte: escape handling; slot 2 carries the fresh byte
        if (i_has_byte && esc != ESC_ENDED) begin
            if (i_byte == 8'd0) begin
                slot_c[0]  = CH_PCT;
                slot_en[0] = (esc == ESC_PCT) || (esc == ESC_DIGIT);
                slot_c[1]  = held;
                slot_en[1] = (esc == ESC_DIGIT);
                esc        = ESC_ENDED;
                cut_after  = 1'b1;
            end else begin
                if (raw != CNT_MAX) raw = raw + 1'b1;
                unique case (esc)
                    ESC_PCT: begin
                        if (hv_in[4]) begin
                            held = i_byte;
                            esc  = ESC_DIGIT;
                        end else begin
                            slot_c[0]  = CH_PCT;
                            slot_en[0] = 1'b1;
                            esc        = ESC_IDLE;
                        end
                    end
                    ESC_DIGIT: begin
                        if (hv_in[4]) begin
                            slot_c[0]  = {hv_held[3:0], hv_in[3:0]};
                            slot_en[0] = 1'b1;
                        end else begin
                            slot_c[0]  = CH_PCT;
                            slot_en[0] = 1'b1;
                            slot_c[1]  = held;
                            slot_en[1] = 1'b1;
                        end
                        esc = ESC_IDLE;
                    end
                    ESC_IDLE, ESC_ENDED: begin
                    end
                endcase
                // Fresh byte once no escape is pending
                if (esc == ESC_IDLE && !(i_ctx.esc == ESC_DIGIT && hv_in[4])) begin
                    if (i_byte == CH_PCT) begin
                        esc = ESC_PCT;
                    end else begin
                        slot_c[2]  = fresh_c;
                        slot_en[2] = 1'b1;
                    end
                end
            end
        end

        // Flush a pending escape at the end of the path
        if (i_last && esc != ESC_ENDED) begin
            slot_c[3]  = CH_PCT;
            slot_en[3] = (esc == ESC_PCT) || (esc == ESC_DIGIT);
            slot_c[4]  = held;
            slot_en[4] = (esc == ESC_DIGIT);
            esc        = ESC_IDLE;
        end

        // Run decoded bytes in order, appending emitted ones
        st = i_ctx.dec;
        n  = 3'd0;
        for (int i = 0; i < NUM_RES; i++) begin
            res[i] = '0;
        end
        for (int i = 0; i < NUM_SLOT; i++) begin
            dr = dec_byte(st, slot_c[i], slot_en[i]);
            st = dr.st;
            if (dr.emit && n < 3'(NUM_RES)) begin
                res[n[1:0]].kind = KIND_BYTE;
                res[n[1:0]].data = dr.data;
                n = n + 1'b1;
            end
        end
        if (cut_after) st.cut = 1'b1;

        // Verdict in priority order
        if (i_path_room <= 13'd1) begin
            err = ERR_NO_ROOM;
        end else if (raw == '0 ||
                     (raw == 13'd1 && st.pos == POS_SLASH && st.path_count == '0)) begin
            err = ERR_OK;
        end else if (raw >= i_max_raw) begin
            err = ERR_RAW_LEN;
        end else if (st.flags[FL_DOTDOT]) begin
            err = ERR_DOTDOT;
        end else if (st.flags[FL_DSLASH]) begin
            err = ERR_DSLASH;
        end else if (st.flags[FL_BADCH]) begin
            err = ERR_BADCH;
        end else if (st.flags[FL_HIDDEN]) begin
            err = ERR_HIDDEN;
        end else if (st.path_count >= i_path_room) begin
            err = ERR_TOOLONG;
        end else begin
            err = ERR_OK;
        end

        if (i_last && n < 3'(NUM_RES)) begin
            res[n[1:0]].kind     = KIND_VERDICT;
            res[n[1:0]].data     = 8'd0;
            res[n[1:0]].accepted = (err == ERR_OK);
            res[n[1:0]].err      = err;
            res[n[1:0]].last     = 1'b1;
            n = n + 1'b1;
        end

        // Next context; the end of a path returns to the start state
        if (i_last) begin
            o_ctx = '0;
        end else begin
            o_ctx.esc       = esc;
            o_ctx.held      = held;
            o_ctx.raw_count = raw;
            o_ctx.dec       = st;
        end
        o_num = n;
        for (int i = 0; i < NUM_RES; i++) begin
            o_res[i] = res[i];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/url_path_decode_validate_top.sv =====
// Top level of the URL path decoder/validator: input register, step logic,
// result queue and configuration registers. Depends on upd_pkg and upd_step.
//
// Usage:
//   s_axis: one raw path byte per item in tdata; tuser is has_byte (0 = no
//   byte, used for an empty path); tlast marks the final item of a path.
//   m_axis: tuser is the kind (0 path byte, 1 verdict); tdata carries the
//   decoded byte with '/' shown as '\', the accepted bit and the error code;
//   tlast is set on the verdict that ends the path.
//   cfg: write of max_raw_length (index 0) or path_room (index 1); always
//   ready. Write only while no item is in flight.
// Flow: an accepted item waits in the input register; its step results are
// then loaded into the result queue, whose head drives m_axis. Throughput:
// one item per cycle while each item causes at most one result and m_axis
// is ready. An item that causes several results (up to four: pending escape
// bytes, the byte itself and the verdict) holds the output until all are
// taken, and the input register waits behind the four-entry result queue.
// Reset clears the path context, the queue and the input register, and loads
// both registers with 1024. When the receiver stalls, results stay in the
// queue and one more item is held in the input register before ready drops.
`default_nettype none

module url_path_decode_validate_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Raw path input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] accepted,
                                             // [11:9] error_code, [15:12] zero
    output logic             m_axis_tuser,   // [0] out_kind
    output logic             m_axis_tlast,
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);
    import upd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_has;
    logic             r_in_last;
    t_ctx             r_ctx;
    t_result          r_ob [NUM_RES];
    logic [2:0]       r_ob_num;
    logic [CNT_W-1:0] r_max_raw;
    logic [CNT_W-1:0] r_path_room;

    t_ctx                    n_ctx;
    t_result [NUM_RES-1:0]   step_res;
    logic [2:0]              step_num;
    logic                    q_free;
    logic                    q_take;
    logic                    do_step;
    logic                    in_acc;

    upd_step u_step (
        .i_ctx       (r_ctx),
        .i_byte      (r_in_byte),
        .i_has_byte  (r_in_has),
        .i_last      (r_in_last),
        .i_max_raw   (r_max_raw),
        .i_path_room (r_path_room),
        .o_ctx       (n_ctx),
        .o_res       (step_res),
        .o_num       (step_num)
    );

    // Handshake control
    assign q_take        = m_axis_tvalid && m_axis_tready;
    assign q_free        = (r_ob_num == 3'd0) || (r_ob_num == 3'd1 && m_axis_tready);
    assign do_step       = r_in_valid && q_free;
    assign s_axis_tready = !r_in_valid || q_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Output from the head of the queue
    assign m_axis_tvalid = (r_ob_num != 3'd0);
    assign m_axis_tdata  = {4'd0, r_ob[0].err, r_ob[0].accepted, r_ob[0].data};
    assign m_axis_tuser  = r_ob[0].kind;
    assign m_axis_tlast  = r_ob[0].last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_ctx       <= '0;
            r_ob_num    <= 3'd0;
            r_max_raw   <= RST_MAX_RAW;
            r_path_room <= RST_PATH_ROOM;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (do_step) begin
                r_in_valid <= 1'b0;
            end
            if (do_step) begin
                r_ctx    <= n_ctx;
                r_ob_num <= step_num;
            end else if (q_take) begin
                r_ob_num <= r_ob_num - 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_RAW:   r_max_raw   <= i_cfg_data;
                    CFG_PATH_ROOM: r_path_room <= i_cfg_data;
                endcase
            end
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= s_axis_tdata;
            r_in_has  <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
        end
    end

    // Result queue payload: load on a step, shift toward the head on a take
    always_ff @(posedge i_clk) begin
        if (do_step) begin
            for (int i = 0; i < NUM_RES; i++) begin
                r_ob[i] <= step_res[i];
            end
        end else if (q_take) begin
            for (int i = 0; i < NUM_RES - 1; i++) begin
                r_ob[i] <= r_ob[i+1];
            end
        end
    end

endmodule

`default_nettype wire
